[sv/lfmm_pkg.sv]
// ----------------------------------------------------------------------------
// lfmm_pkg: shared types and constants for the line follow mode controller
// Mode and action codes, register indexes, reset values and bundles.
// ----------------------------------------------------------------------------
package lfmm_pkg;

  localparam int PWM_W  = 15;
  localparam int LVL_W  = 16;
  localparam int MASK_W = 4;
  localparam int CNT_W  = 8;
  localparam int IDX_W  = 3;

  typedef enum logic [2:0] {
    MODE_STOP   = 3'd0,
    MODE_TRACK  = 3'd1,
    MODE_TURN   = 3'd2,
    MODE_SEARCH = 3'd3,
    MODE_WIDE   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_START  = 2'd1,
    ACT_STOP   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // register indexes
  localparam logic [IDX_W-1:0] REG_STRAIGHT     = 3'd0;
  localparam logic [IDX_W-1:0] REG_SLOW         = 3'd1;
  localparam logic [IDX_W-1:0] REG_OUTER        = 3'd2;
  localparam logic [IDX_W-1:0] REG_TURN         = 3'd3;
  localparam logic [IDX_W-1:0] REG_FILTER       = 3'd4;
  localparam logic [IDX_W-1:0] REG_SEARCH_RIGHT = 3'd5;

  // register reset values
  localparam logic [PWM_W-1:0] DEF_STRAIGHT     = 15'd600;
  localparam logic [PWM_W-1:0] DEF_SLOW         = 15'd300;
  localparam logic [PWM_W-1:0] DEF_OUTER        = 15'd700;
  localparam logic [PWM_W-1:0] DEF_TURN         = 15'd500;
  localparam logic [CNT_W-1:0] DEF_FILTER       = 8'd2;
  localparam logic             DEF_SEARCH_RIGHT = 1'b0;

  // sensor masks: bit0 left outer, bit1 left inner, bit2 right inner, bit3 right outer
  localparam logic [MASK_W-1:0] MASK_NONE     = 4'b0000;
  localparam logic [MASK_W-1:0] MASK_LO       = 4'b0001;
  localparam logic [MASK_W-1:0] MASK_LI       = 4'b0010;
  localparam logic [MASK_W-1:0] MASK_LO_LI    = 4'b0011;
  localparam logic [MASK_W-1:0] MASK_RI       = 4'b0100;
  localparam logic [MASK_W-1:0] MASK_CENTER   = 4'b0110;
  localparam logic [MASK_W-1:0] MASK_RO       = 4'b1000;
  localparam logic [MASK_W-1:0] MASK_RO_RI    = 4'b1100;

  typedef struct packed {
    logic [PWM_W-1:0] straight_pwm;
    logic [PWM_W-1:0] slow_pwm;
    logic [PWM_W-1:0] outer_pwm;
    logic [PWM_W-1:0] turn_pwm;
  } pwm_cfg_t;

  typedef struct packed {
    mode_t                    mode;
    logic signed [LVL_W-1:0]  left;
    logic signed [LVL_W-1:0]  right;
    logic                     heading_right;
  } drive_t;

endpackage

[sv/lfmm_drive.sv]
// ----------------------------------------------------------------------------
// lfmm_drive: mask to mode and wheel level decode
// Maps the debounced sensor mask to a mode, signed wheel levels and heading.
// ----------------------------------------------------------------------------
module lfmm_drive (
  input  lfmm_pkg::pwm_cfg_t           cfg,
  input  logic [lfmm_pkg::MASK_W-1:0]  held,
  input  logic                         heading_in,
  output lfmm_pkg::drive_t             drive
);
  import lfmm_pkg::*;

  logic signed [LVL_W-1:0] straight_lvl;
  logic signed [LVL_W-1:0] slow_lvl;
  logic signed [LVL_W-1:0] outer_lvl;
  logic signed [LVL_W-1:0] turn_lvl;
  logic                    pivot_right;
  logic signed [LVL_W-1:0] pivot_left;

  assign straight_lvl = $signed({1'b0, cfg.straight_pwm});
  assign slow_lvl     = $signed({1'b0, cfg.slow_pwm});
  assign outer_lvl    = $signed({1'b0, cfg.outer_pwm});
  assign turn_lvl     = $signed({1'b0, cfg.turn_pwm});

  // turn: heading from which outer sensor fired; search: keep recorded heading
  always_comb begin
    if (held == MASK_NONE) begin
      pivot_right = heading_in;
    end else begin
      pivot_right = ~held[0];
    end
  end

  assign pivot_left = pivot_right ? turn_lvl : -turn_lvl;

  always_comb begin
    drive.heading_right = heading_in;
    unique case (held)
      MASK_CENTER: begin
        drive.mode  = MODE_TRACK;
        drive.left  = straight_lvl;
        drive.right = straight_lvl;
      end
      MASK_LI: begin
        drive.mode          = MODE_TRACK;
        drive.left          = slow_lvl;
        drive.right         = outer_lvl;
        drive.heading_right = 1'b0;
      end
      MASK_RI: begin
        drive.mode          = MODE_TRACK;
        drive.left          = outer_lvl;
        drive.right         = slow_lvl;
        drive.heading_right = 1'b1;
      end
      MASK_LO, MASK_LO_LI, MASK_RO, MASK_RO_RI: begin
        drive.mode          = MODE_TURN;
        drive.left          = pivot_left;
        drive.right         = -pivot_left;
        drive.heading_right = pivot_right;
      end
      MASK_NONE: begin
        drive.mode  = MODE_SEARCH;
        drive.left  = pivot_left;
        drive.right = -pivot_left;
      end
      default: begin
        drive.mode  = MODE_WIDE;
        drive.left  = slow_lvl;
        drive.right = slow_lvl;
      end
    endcase
  end

endmodule

[sv/line_follow_motor_mode_controller.sv]
// ----------------------------------------------------------------------------
// line_follow_motor_mode_controller: debounced line sensor to motor commands
// Start/stop/sample beats in, one status beat out per input beat.
// ----------------------------------------------------------------------------
// Pipeline: input register, then the state/result register loaded by the
//   combinational decode.
// Throughput: one beat per cycle; the input register can take a beat while
//   a result waits, and stalls when both stages are full and m_axis_tready is low.
// Reset (rst, synchronous): stopped, levels zero, filter cleared, registers
//   back to their default values.
// ----------------------------------------------------------------------------
module line_follow_motor_mode_controller (
  input  logic                          clk,
  input  logic                          rst,
  // input stream; s_axis_tdata: action[1:0], sensor_mask[5:2], stop_reason[6], 0[7]
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,
  // result stream; m_axis_tdata: mode_now[2:0], left_drive[18:3],
  //   right_drive[34:19], reason_now[35], accepted_mask[39:36]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [39:0]                   m_axis_tdata,
  // register write port
  input  logic                          cfg_we,
  input  logic [lfmm_pkg::IDX_W-1:0]    cfg_index,
  input  logic [lfmm_pkg::PWM_W-1:0]    cfg_data
);
  import lfmm_pkg::*;

  // configuration registers
  pwm_cfg_t         pwm_cfg;
  logic [CNT_W-1:0] filter_samples;
  logic             default_search_right;

  // input stage
  logic              in_full;
  action_t           in_action;
  logic [MASK_W-1:0] in_mask;
  logic              in_reason;

  // controller state; it is also the result held for the output side
  mode_t                   run_mode;
  logic                    run_reason;
  logic signed [LVL_W-1:0] left_level;
  logic signed [LVL_W-1:0] right_level;
  logic                    heading_right;
  logic [MASK_W-1:0]       pending_mask;
  logic [MASK_W-1:0]       held_mask;
  logic [CNT_W-1:0]        repeat_count;
  logic                    primed;
  logic                    out_valid;

  // next values
  mode_t                   run_mode_next;
  logic                    run_reason_next;
  logic signed [LVL_W-1:0] left_level_next;
  logic signed [LVL_W-1:0] right_level_next;
  logic                    heading_right_next;
  logic [MASK_W-1:0]       pending_mask_next;
  logic [MASK_W-1:0]       held_mask_next;
  logic [CNT_W-1:0]        repeat_count_next;
  logic                    primed_next;

  logic   fire;      // input stage item is processed this cycle
  drive_t drive;

  assign fire          = in_full & (~out_valid | m_axis_tready);
  assign s_axis_tready = ~in_full | fire;

  // config writes: the user writes only while idle; the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_cfg.straight_pwm <= DEF_STRAIGHT;
      pwm_cfg.slow_pwm     <= DEF_SLOW;
      pwm_cfg.outer_pwm    <= DEF_OUTER;
      pwm_cfg.turn_pwm     <= DEF_TURN;
      filter_samples       <= DEF_FILTER;
      default_search_right <= DEF_SEARCH_RIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STRAIGHT:     pwm_cfg.straight_pwm <= cfg_data;
        REG_SLOW:         pwm_cfg.slow_pwm     <= cfg_data;
        REG_OUTER:        pwm_cfg.outer_pwm    <= cfg_data;
        REG_TURN:         pwm_cfg.turn_pwm     <= cfg_data;
        REG_FILTER:       filter_samples       <= cfg_data[CNT_W-1:0];
        REG_SEARCH_RIGHT: default_search_right <= cfg_data[0];
        default: ;  // indexes past the list are dropped
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_axis_tready) begin
      in_full <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_action <= action_t'(s_axis_tdata[1:0]);
      in_mask   <= s_axis_tdata[5:2];
      in_reason <= s_axis_tdata[6];
    end
  end

  // mode and level decode of the freshly filtered mask
  lfmm_drive u_drive (
    .cfg        (pwm_cfg),
    .held       (held_mask_next),
    .heading_in (heading_right),
    .drive      (drive)
  );

  // debounce filter; a start from stop clears it
  always_comb begin
    pending_mask_next = pending_mask;
    held_mask_next    = held_mask;
    repeat_count_next = repeat_count;
    primed_next       = primed;

    unique case (in_action)
      ACT_SAMPLE: begin
        // first sample after start is taken at once; a change restarts the
        // count, a repeat counts up to filter_samples
        if (!primed) begin
          pending_mask_next = in_mask;
          held_mask_next    = in_mask;
          repeat_count_next = CNT_W'(1);
          primed_next       = 1'b1;
        end else if (in_mask != pending_mask) begin
          pending_mask_next = in_mask;
          repeat_count_next = CNT_W'(1);
        end else if (repeat_count < filter_samples) begin
          repeat_count_next = repeat_count + CNT_W'(1);
        end
        if (repeat_count_next >= filter_samples) begin
          held_mask_next = pending_mask_next;
        end
      end
      ACT_START: begin
        if (run_mode == MODE_STOP) begin
          pending_mask_next = '0;
          held_mask_next    = '0;
          repeat_count_next = '0;
          primed_next       = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    run_mode_next      = run_mode;
    run_reason_next    = run_reason;
    left_level_next    = left_level;
    right_level_next   = right_level;
    heading_right_next = heading_right;

    unique case (in_action)
      ACT_SAMPLE: begin
        // while stopped only the filter moves
        if (run_mode != MODE_STOP) begin
          run_mode_next      = drive.mode;
          left_level_next    = drive.left;
          right_level_next   = drive.right;
          heading_right_next = drive.heading_right;
        end
      end
      ACT_START: begin
        if (run_mode == MODE_STOP) begin
          heading_right_next = default_search_right;
          run_mode_next      = MODE_TRACK;
          left_level_next    = '0;
          right_level_next   = '0;
          run_reason_next    = 1'b1;
        end
      end
      ACT_STOP: begin
        run_mode_next    = MODE_STOP;
        left_level_next  = '0;
        right_level_next = '0;
        run_reason_next  = in_reason;
      end
      default: ;  // unused action: state unchanged, result still sent
    endcase
  end

  // state / result register
  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode      <= MODE_STOP;
      run_reason    <= 1'b0;
      left_level    <= '0;
      right_level   <= '0;
      heading_right <= DEF_SEARCH_RIGHT;
      pending_mask  <= '0;
      held_mask     <= '0;
      repeat_count  <= '0;
      primed        <= 1'b0;
    end else if (fire) begin
      run_mode      <= run_mode_next;
      run_reason    <= run_reason_next;
      left_level    <= left_level_next;
      right_level   <= right_level_next;
      heading_right <= heading_right_next;
      pending_mask  <= pending_mask_next;
      held_mask     <= held_mask_next;
      repeat_count  <= repeat_count_next;
      primed        <= primed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // state only moves on fire, which also reloads the result beat
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {held_mask, run_reason, right_level, left_level, run_mode};

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for line_follow_motor_mode_controller
// A directed pass covers the power-up defaults, every sensor pattern, the
// start/stop rules and the register extremes. Random sample runs, start and
// stop beats then follow under three backpressure profiles. Every output beat
// is checked against a cycle-free model of the controller kept in this file.
// ----------------------------------------------------------------------------
module tb_top;
  import lfmm_pkg::*;

  // indexes past the register map; writes there must have no effect
  localparam logic [IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [IDX_W-1:0] REG_UNUSED_HI = 3'd7;
  localparam int               MAX_SHOWN     = 10;

  // one status beat as the block reports it
  typedef struct packed {
    mode_t                   mode;
    logic signed [LVL_W-1:0] left;
    logic signed [LVL_W-1:0] right;
    logic                    reason;
    logic [MASK_W-1:0]       mask;
  } status_t;

  logic              clk;
  logic              rst;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  // action[1:0], sensor_mask[5:2], stop_reason[6], zero[7]
  logic [7:0]        s_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  // mode_now[2:0], left_drive[18:3], right_drive[34:19], reason_now[35],
  // accepted_mask[39:36]
  logic [39:0]       m_axis_tdata;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [PWM_W-1:0]  cfg_data;

  // backpressure knobs, percent of cycles spent idle
  int src_idle_pct;
  int dst_idle_pct;
  int mismatches = 0;

  // status beats still owed by the block, oldest first
  status_t status_q[$];

  // shadow of the register file
  logic [PWM_W-1:0]  cfg_straight;
  logic [PWM_W-1:0]  cfg_slow;
  logic [PWM_W-1:0]  cfg_outer;
  logic [PWM_W-1:0]  cfg_turn;
  logic [CNT_W-1:0]  cfg_filter;
  logic              cfg_search_right;

  // shadow of the controller state
  mode_t                   ctl_mode;
  logic                    ctl_reason;
  logic signed [LVL_W-1:0] ctl_left;
  logic signed [LVL_W-1:0] ctl_right;
  logic                    ctl_heading_right;
  logic [MASK_W-1:0]       ctl_pending;
  logic [MASK_W-1:0]       ctl_held;
  logic [CNT_W-1:0]        ctl_count;
  logic                    ctl_primed;

  line_follow_motor_mode_controller dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Controller model
  // --------------------------------------------------------------------------

  // stopped, filter empty, heading from the search-direction register
  function automatic void clear_controller();
    ctl_pending       = MASK_NONE;
    ctl_held          = MASK_NONE;
    ctl_count         = '0;
    ctl_primed        = 1'b0;
    ctl_heading_right = cfg_search_right;
    ctl_mode          = MODE_STOP;
    ctl_left          = '0;
    ctl_right         = '0;
    ctl_reason        = 1'b0;
  endfunction

  // apply one input beat, return the status beat it produces
  function automatic status_t step_controller(action_t act, logic [MASK_W-1:0] raw,
                                              logic why);
    logic signed [LVL_W-1:0] mag;
    status_t                 s;
    case (act)
      ACT_SAMPLE: begin
        // debounce: first sample after start/reset passes straight through
        if (!ctl_primed) begin
          ctl_pending = raw;
          ctl_held    = raw;
          ctl_count   = 8'd1;
          ctl_primed  = 1'b1;
        end else if (raw != ctl_pending) begin
          ctl_pending = raw;
          ctl_count   = 8'd1;
        end else if (ctl_count < cfg_filter) begin
          ctl_count = ctl_count + 8'd1;
        end
        // a zero filter setting makes this always true
        if (ctl_count >= cfg_filter) ctl_held = ctl_pending;
        // stopped: filter moves, drive stays put
        if (ctl_mode != MODE_STOP) begin
          case (ctl_held)
            MASK_CENTER: begin
              ctl_mode  = MODE_TRACK;
              ctl_left  = {1'b0, cfg_straight};
              ctl_right = {1'b0, cfg_straight};
            end
            MASK_LI: begin
              ctl_heading_right = 1'b0;
              ctl_mode  = MODE_TRACK;
              ctl_left  = {1'b0, cfg_slow};
              ctl_right = {1'b0, cfg_outer};
            end
            MASK_RI: begin
              ctl_heading_right = 1'b1;
              ctl_mode  = MODE_TRACK;
              ctl_left  = {1'b0, cfg_outer};
              ctl_right = {1'b0, cfg_slow};
            end
            MASK_LO, MASK_LO_LI, MASK_RO, MASK_RO_RI: begin
              ctl_heading_right = ~ctl_held[0];
              ctl_mode = MODE_TURN;
            end
            MASK_NONE: ctl_mode = MODE_SEARCH;
            default: begin
              ctl_mode  = MODE_WIDE;
              ctl_left  = {1'b0, cfg_slow};
              ctl_right = {1'b0, cfg_slow};
            end
          endcase
          // turn and search both pivot in place toward the heading
          if (ctl_mode == MODE_TURN || ctl_mode == MODE_SEARCH) begin
            mag       = {1'b0, cfg_turn};
            ctl_left  = ctl_heading_right ? mag : -mag;
            ctl_right = -ctl_left;
          end
        end
      end
      ACT_START: begin
        // only honored from stop
        if (ctl_mode == MODE_STOP) begin
          clear_controller();
          ctl_mode   = MODE_TRACK;
          ctl_reason = 1'b1;
        end
      end
      ACT_STOP: begin
        ctl_mode   = MODE_STOP;
        ctl_left   = '0;
        ctl_right  = '0;
        ctl_reason = why;
      end
      default: ;
    endcase
    s.mode   = ctl_mode;
    s.left   = ctl_left;
    s.right  = ctl_right;
    s.reason = ctl_reason;
    s.mask   = ctl_held;
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // entered and left at a falling edge; valid stays up after the beat so a
  // back-to-back beat never drops it
  task automatic send_beat(action_t act, logic [MASK_W-1:0] raw, logic why);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tdata  = {1'b0, why, raw, act};
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    status_q.push_back(step_controller(act, raw, why));
    @(negedge clk);
  endtask

  // drop valid, then wait for every owed status beat
  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    while (status_q.size() != 0) @(negedge clk);
  endtask

  // one-cycle register write; block must be idle
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [PWM_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_STRAIGHT:     cfg_straight     = data;
      REG_SLOW:         cfg_slow         = data;
      REG_OUTER:        cfg_outer        = data;
      REG_TURN:         cfg_turn         = data;
      REG_FILTER:       cfg_filter       = data[CNT_W-1:0];
      REG_SEARCH_RIGHT: cfg_search_right = data[0];
      default: ;
    endcase
  endtask

  // receiver stalls at random, updated on the falling edge
  always @(negedge clk) begin
    m_axis_tready = ($urandom_range(0, 99) >= dst_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Result checker: every accepted status beat against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    status_t got;
    status_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.mode   = mode_t'(m_axis_tdata[2:0]);
      got.left   = m_axis_tdata[18:3];
      got.right  = m_axis_tdata[34:19];
      got.reason = m_axis_tdata[35];
      got.mask   = m_axis_tdata[39:36];
      if (status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected beat: mode %0d left %0d right %0d reason %0d mask %h",
                   got.mode, $signed(got.left), $signed(got.right), got.reason, got.mask);
      end else begin
        want = status_q.pop_front();
        if (got.mode !== want.mode || got.left !== want.left ||
            got.right !== want.right || got.reason !== want.reason ||
            got.mask !== want.mask) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("mismatch: exp mode %0d left %0d right %0d reason %0d mask %h",
                     want.mode, $signed(want.left), $signed(want.right),
                     want.reason, want.mask);
            $display("          got mode %0d left %0d right %0d reason %0d mask %h",
                     got.mode, $signed(got.left), $signed(got.right),
                     got.reason, got.mask);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // power-up registers; samples before start only feed the filter
  task automatic test_defaults_after_reset();
    send_beat(ACT_SAMPLE, MASK_RI, 1'b1);     // stopped: mode/levels hold, mask taken
    send_beat(ACT_START, MASK_RO, 1'b0);      // filter cleared, track at zero levels
    send_beat(ACT_SAMPLE, MASK_CENTER, 1'b0); // first sample passes at once
    send_beat(ACT_SAMPLE, MASK_LI, 1'b0);     // one of two needed: still centered
    drain_results();
  endtask

  // all sixteen patterns, filter of one, PWMs at their extremes
  task automatic test_mask_decode();
    write_reg(REG_STRAIGHT, 15'h7fff);
    write_reg(REG_SLOW, 15'h0000);
    write_reg(REG_OUTER, 15'h7fff);
    write_reg(REG_TURN, 15'h7fff);
    write_reg(REG_FILTER, 15'd1);
    for (int m = 0; m < 16; m++) send_beat(ACT_SAMPLE, m[MASK_W-1:0], 1'b0);
    drain_results();
  endtask

  // start only from stop, stop latches its reason, unused action is a no-op
  task automatic test_start_stop();
    send_beat(ACT_START, MASK_NONE, 1'b0);   // running: ignored, heading kept
    send_beat(ACT_STOP, MASK_CENTER, 1'b1);  // reason ok
    send_beat(ACT_SAMPLE, MASK_LO, 1'b0);    // stopped sample
    send_beat(ACT_NONE, 4'hf, 1'b1);         // unused code
    send_beat(ACT_START, MASK_NONE, 1'b1);
    send_beat(ACT_STOP, 4'hf, 1'b0);         // user stop
    drain_results();
  endtask

  // zero filter, right-hand default search, writes past the register map
  task automatic test_register_extremes();
    write_reg(REG_STRAIGHT, 15'h0000);
    write_reg(REG_SLOW, 15'h7fff);
    write_reg(REG_OUTER, 15'h0000);
    write_reg(REG_FILTER, 15'd0);
    write_reg(REG_SEARCH_RIGHT, 15'd1);
    write_reg(REG_UNUSED_LO, 15'h7fff);
    write_reg(REG_UNUSED_HI, 15'h7fff);
    send_beat(ACT_START, MASK_NONE, 1'b0);
    send_beat(ACT_SAMPLE, MASK_NONE, 1'b0);  // searches right straight away
    send_beat(ACT_SAMPLE, 4'b1001, 1'b0);    // both outers: wide
    drain_results();
    write_reg(REG_FILTER, 15'd255);
  endtask

  // random registers, then runs of identical samples broken by noise, stops
  // and restarts; ignored beats are not counted
  task automatic test_random_traffic(int items, int src_pct, int dst_pct);
    int                sent;
    int                pick;
    int                len;
    logic [MASK_W-1:0] raw;
    src_idle_pct = src_pct;
    dst_idle_pct = dst_pct;
    for (int setting = 0; setting < 2; setting++) begin
      drain_results();
      write_reg(REG_STRAIGHT, PWM_W'($urandom_range(0, 32767)));
      write_reg(REG_SLOW, PWM_W'($urandom_range(0, 32767)));
      write_reg(REG_OUTER, PWM_W'($urandom_range(0, 32767)));
      write_reg(REG_TURN, PWM_W'($urandom_range(0, 32767)));
      pick = $urandom_range(0, 19);
      // mostly short filters so masks change often; rarely none or the longest
      write_reg(REG_FILTER, (pick == 0) ? 15'd0 :
                            (pick == 1) ? 15'd255 : PWM_W'($urandom_range(1, 6)));
      write_reg(REG_SEARCH_RIGHT, PWM_W'($urandom_range(0, 1)));
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_UNUSED_LO : REG_UNUSED_HI,
                  PWM_W'($urandom));
      sent = 0;
      while (sent < items / 2) begin
        pick = $urandom_range(0, 99);
        if (ctl_mode == MODE_STOP && pick < 60) begin
          send_beat(ACT_START, MASK_W'($urandom), 1'($urandom));
          sent++;
        end else if (pick < 5) begin
          send_beat(ACT_STOP, MASK_W'($urandom), 1'($urandom));
          sent++;
        end else if (pick < 8) begin
          // start while running: no effect
          send_beat(ACT_START, MASK_W'($urandom), 1'($urandom));
        end else if (pick < 10) begin
          send_beat(ACT_NONE, MASK_W'($urandom), 1'($urandom));
        end else begin
          // a run of one to cfg_filter + 2 samples, now and then broken
          raw = MASK_W'($urandom);
          len = $urandom_range(1, int'(cfg_filter) + 2);
          for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 99) < 8)
              send_beat(ACT_SAMPLE, MASK_W'($urandom), 1'($urandom));
            else
              send_beat(ACT_SAMPLE, raw, 1'($urandom));
            sent++;
          end
        end
      end
    end
    drain_results();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we        = 1'b0;
    cfg_index     = REG_STRAIGHT;
    cfg_data      = '0;
    src_idle_pct  = 30;
    dst_idle_pct  = 73;

    // model starts from the power-up register values
    cfg_straight     = DEF_STRAIGHT;
    cfg_slow         = DEF_SLOW;
    cfg_outer        = DEF_OUTER;
    cfg_turn         = DEF_TURN;
    cfg_filter       = DEF_FILTER;
    cfg_search_right = DEF_SEARCH_RIGHT;
    clear_controller();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_defaults_after_reset();
    test_mask_decode();
    test_start_stop();
    test_register_extremes();
    test_random_traffic(460, 30, 73);
    test_random_traffic(460, 73, 30);
    test_random_traffic(460, 0, 0);

    // a quiet wait to catch any stray beat
    drain_results();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && status_q.size() == 0) begin
      $display("PASS line_follow_motor_mode_controller");
    end else begin
      $display("FAIL line_follow_motor_mode_controller");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #400000;
    $display("FAIL line_follow_motor_mode_controller");
    $finish;
  end

endmodule

[filelist.f]
sv/lfmm_pkg.sv
sv/lfmm_drive.sv
sv/line_follow_motor_mode_controller.sv
verif/tb_top.sv
